[sv/signed_divide_by_constant_assert.svh]
`ifndef SIGNED_DIVIDE_BY_CONSTANT_ASSERT_SVH
`define SIGNED_DIVIDE_BY_CONSTANT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SDC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/sdc_pkg.sv]
package sdc_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int STATUS_W   = 2;

	// datapath selected by the divisor
	localparam logic [1:0] PATH_IDENT = 2'd0;
	localparam logic [1:0] PATH_NEG   = 2'd1;
	localparam logic [1:0] PATH_POW2  = 2'd2;
	localparam logic [1:0] PATH_MAGIC = 2'd3;

	// result status
	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_DIVZERO = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_OVF     = 2'd2;

	typedef struct packed {
		logic       busy;  // constants being derived
		logic [1:0] path;
		logic       neg;   // divisor negative
		logic       zero;  // divisor zero
	} sdc_ctrl_t;

endpackage

[sv/sdc_setup.sv]
// Derives path, magic multiplier and shift from a divisor write.
// Sequencer: scan for log2, restoring division of 2^(W-1+l) by |d|,
// increment, then strip trailing zeros.
module sdc_setup #(
	parameter int WIDTH = sdc_pkg::DATA_WIDTH,
	localparam int LW = $clog2(WIDTH + 1),
	localparam int CW = $clog2(2 * WIDTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               divisor_we,
	input  logic [WIDTH-1:0]   divisor,
	output sdc_pkg::sdc_ctrl_t ctrl,
	output logic [WIDTH-1:0]   magic,
	output logic [LW-1:0]      shift
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_INC  = 3'd3;
	localparam logic [2:0] ST_RED  = 3'd4;

	logic [2:0]       state_q;
	logic [WIDTH-1:0] div_q;
	logic [WIDTH-1:0] mag_q;
	logic [WIDTH-1:0] tmp_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] magic_q;
	logic [LW-1:0]    shift_q;
	logic [CW-1:0]    cnt_q;
	logic [1:0]       path_q;

	logic [WIDTH-1:0] wr_mag;
	logic             is_pow2;
	logic [WIDTH:0]   rem_sh;
	logic             rem_ge;

	assign wr_mag  = divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;
	assign is_pow2 = ((mag_q & (mag_q - 1'b1)) == '0);
	assign rem_sh  = {rem_q, 1'b0};
	assign rem_ge  = (rem_sh >= {1'b0, mag_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_q   <= WIDTH'(1);
			path_q  <= sdc_pkg::PATH_IDENT;
			magic_q <= '0;
			shift_q <= '0;
		end else if (divisor_we) begin
			// a new divisor restarts the derivation from any state
			div_q   <= divisor;
			mag_q   <= wr_mag;
			tmp_q   <= wr_mag;
			magic_q <= '0;
			shift_q <= '0;
			path_q  <= sdc_pkg::PATH_IDENT;
			state_q <= ST_SCAN;
		end else begin
			case (state_q)
				ST_IDLE: ;
				ST_SCAN: begin
					if (|tmp_q[WIDTH-1:1]) begin
						tmp_q   <= tmp_q >> 1;
						shift_q <= shift_q + 1'b1;
					end else if (mag_q[WIDTH-1:1] == '0) begin
						// zero, one or minus one
						path_q  <= (mag_q[0] && div_q[WIDTH-1]) ? sdc_pkg::PATH_NEG
						                                        : sdc_pkg::PATH_IDENT;
						state_q <= ST_IDLE;
					end else if (is_pow2) begin
						path_q  <= sdc_pkg::PATH_POW2;
						state_q <= ST_IDLE;
					end else begin
						// l = log2 + 1; leading dividend bit preloaded into rem
						shift_q <= shift_q + 1'b1;
						rem_q   <= WIDTH'(1);
						quo_q   <= '0;
						cnt_q   <= CW'(WIDTH) + CW'(shift_q);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q   <= rem_ge ? WIDTH'(rem_sh - {1'b0, mag_q}) : rem_sh[WIDTH-1:0];
					quo_q   <= {quo_q[WIDTH-2:0], rem_ge};
					cnt_q   <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= ST_INC;
					end
				end
				ST_INC: begin
					magic_q <= quo_q + 1'b1;
					state_q <= ST_RED;
				end
				ST_RED: begin
					if (!magic_q[0] && (shift_q > LW'(1))) begin
						magic_q <= magic_q >> 1;
						shift_q <= shift_q - 1'b1;
					end else begin
						path_q  <= sdc_pkg::PATH_MAGIC;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign ctrl.busy = (state_q != ST_IDLE);
	assign ctrl.path = path_q;
	assign ctrl.neg  = div_q[WIDTH-1];
	assign ctrl.zero = (div_q == '0);
	assign magic     = magic_q;
	assign shift     = shift_q;

endmodule

[sv/signed_divide_by_constant.sv]
// Signed divide by a programmed constant, truncating toward zero. Write the divisor
// through divisor_we/divisor while no item is in flight; the block then derives its
// constants and holds s_tready low from the write cycle until they are ready
// (a log2 scan of |divisor|, a one-bit-per-cycle division of 2^(WIDTH-1+l)
// by |divisor|, and a trailing-zero strip; divisors 0, 1, -1 and powers of two finish
// after the scan). A later write restarts the derivation at once.
// After that one dividend is taken per cycle while m_tready does not hold the pipeline;
// each quotient passes the input register, one signed WIDTH x WIDTH multiplier stage, and
// the result register, so the multiplier sets the clock. Divisor 1 passes the value
// through, -1 negates it, a power-of-two magnitude uses bias and arithmetic shift,
// any other value a magic multiply-high, shift and sign fix. m_tuser carries status:
// 0 ok, 1 divisor zero (quotient 0), 2 overflow on MIN / -1 (quotient wraps to MIN).
// The three stages fill independently, so items keep coming in while a result waits, until stages 1 and 2 are full.
module signed_divide_by_constant #(
	parameter int WIDTH = sdc_pkg::DATA_WIDTH,
	localparam int TDW = ((WIDTH + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [TDW-1:0]               s_tdata,   // [WIDTH-1:0] dividend, rest zero
	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [TDW-1:0]               m_tdata,   // [WIDTH-1:0] quotient, rest zero
	output logic [sdc_pkg::STATUS_W-1:0] m_tuser,   // [1:0] status
	// divisor register
	input  logic                         divisor_we,
	input  logic [WIDTH-1:0]             divisor
);

	localparam int LW = $clog2(WIDTH + 1);
	localparam logic [WIDTH-1:0] MIN_VAL = {1'b1, {(WIDTH-1){1'b0}}};

	sdc_pkg::sdc_ctrl_t ctrl;
	logic [WIDTH-1:0]   magic;
	logic [LW-1:0]      shift;

	sdc_setup #(.WIDTH(WIDTH)) u_setup (
		.clk        (clk),
		.arst_n     (arst_n),
		.divisor_we (divisor_we),
		.divisor    (divisor),
		.ctrl       (ctrl),
		.magic      (magic),
		.shift      (shift)
	);

	// stage advance: a stage moves when it is empty or its successor moves
	logic en_s1, en_s2, en_s3;
	logic v_s1, v_s2, v_s3;

	assign en_s3    = !v_s3 || m_tready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1 && !ctrl.busy && !divisor_we;

	// stage 1: dividend
	logic [WIDTH-1:0] n_s1;
	logic [WIDTH-1:0] bias_s1;

	// negative dividends get 2^l - 1 added before the shift so it rounds toward zero
	assign bias_s1 = n_s1[WIDTH-1] ? ~({WIDTH{1'b1}} << shift) : '0;

	// stage 2: product and biased dividend
	logic [WIDTH-1:0]          n_s2;
	logic signed [2*WIDTH-1:0] prod_s2;
	logic [WIDTH-1:0]          sum_s2;

	// stage 3 logic
	logic [WIDTH-1:0]             hw;
	logic [WIDTH-1:0]             qd;
	logic [WIDTH-1:0]             sgn;
	logic [WIDTH-1:0]             q_magic;
	logic [WIDTH-1:0]             qs;
	logic [WIDTH-1:0]             q_pow2;
	logic [WIDTH-1:0]             q_nxt;
	logic [sdc_pkg::STATUS_W-1:0] st_nxt;

	// multiplier is stored as an unsigned WIDTH-bit value; when its top bit is set the
	// signed multiply saw m - 2^WIDTH, so add the dividend back in
	assign hw      = prod_s2[2*WIDTH-1:WIDTH] + (magic[WIDTH-1] ? n_s2 : '0);
	assign qd      = $signed(hw) >>> (shift - LW'(1));
	assign sgn     = {WIDTH{n_s2[WIDTH-1]}};
	assign q_magic = ctrl.neg ? (sgn - qd) : (qd - sgn);
	assign qs      = $signed(sum_s2) >>> shift;
	assign q_pow2  = ctrl.neg ? ('0 - qs) : qs;

	always_comb begin
		st_nxt = sdc_pkg::STAT_OK;
		case (ctrl.path)
			sdc_pkg::PATH_IDENT: q_nxt = n_s2;
			sdc_pkg::PATH_NEG: begin
				q_nxt = '0 - n_s2;
				if (n_s2 == MIN_VAL) begin
					st_nxt = sdc_pkg::STAT_OVF;
				end
			end
			sdc_pkg::PATH_POW2:  q_nxt = q_pow2;
			sdc_pkg::PATH_MAGIC: q_nxt = q_magic;
			default:             q_nxt = n_s2;
		endcase
		if (ctrl.zero) begin
			q_nxt  = '0;
			st_nxt = sdc_pkg::STAT_DIVZERO;
		end
	end

	// stage 3: result register
	logic [WIDTH-1:0]             quotient_s3;
	logic [sdc_pkg::STATUS_W-1:0] status_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= s_tvalid && s_tready;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_tvalid && s_tready) begin
			n_s1 <= s_tdata[WIDTH-1:0];
		end
		if (en_s2) begin
			n_s2    <= n_s1;
			prod_s2 <= $signed(n_s1) * $signed(magic);
			sum_s2  <= n_s1 + bias_s1;
		end
		if (en_s3) begin
			quotient_s3 <= q_nxt;
			status_s3   <= st_nxt;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = TDW'(quotient_s3);
	assign m_tuser  = status_s3;

endmodule

[sv/sdc_checker.sv]
`include "signed_divide_by_constant_assert.svh"

// Port-level checks on the divider.
module sdc_checker #(
	parameter int WIDTH = sdc_pkg::DATA_WIDTH,
	localparam int TDW = ((WIDTH + 7) / 8) * 8
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [TDW-1:0]               m_tdata,
	input logic [sdc_pkg::STATUS_W-1:0] m_tuser,
	input logic                         divisor_we
);

	// a stalled result holds
	`SDC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// no item taken while constants are being derived
	`SDC_ASSERT_NEXT(a_setup_stall, divisor_we, !s_tready, "input accepted right after divisor write")

	// overflow wraps to MIN
	`SDC_ASSERT_SAME(a_ovf_min, m_tvalid && (m_tuser == sdc_pkg::STAT_OVF), m_tdata[WIDTH-1] && (m_tdata[WIDTH-2:0] == '0), "overflow quotient is not MIN")

	// divide by zero gives quotient zero
	`SDC_ASSERT_SAME(a_dz_zero, m_tvalid && (m_tuser == sdc_pkg::STAT_DIVZERO), m_tdata == '0, "divide by zero quotient not zero")

endmodule

bind signed_divide_by_constant sdc_checker #(.WIDTH(WIDTH)) u_sdc_checker (.*);

[dv/testbench.sv]
// Self-checking bench for signed_divide_by_constant.
// A driver process feeds dividends from dividend_queue onto the s_ stream. A monitor
// process takes quotients off the m_ stream. Each accepted dividend is divided here,
// by the divisor last written, and the expected quotient and status are queued.
// Each returned item is checked against the oldest entry in that queue.
// The divisor is only written with the block drained. Phases cover fixed divisors
// (1, -1, 0, powers of two, MIN, MAX, small odd and even values), then random ones.
module testbench;

	localparam int W           = 32;
	localparam int HOLD_CYCLES = 300;   // long receiver back-pressure
	localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};

	typedef struct packed {
		logic [W-1:0]                 dividend;
		logic [W-1:0]                 quotient;
		logic [sdc_pkg::STATUS_W-1:0] status;
	} quot_item_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         s_tvalid   = 1'b0;
	logic                         s_tready;
	logic [W-1:0]                 s_tdata    = '0;
	logic                         m_tvalid;
	logic                         m_tready   = 1'b0;
	logic [W-1:0]                 m_tdata;
	logic [sdc_pkg::STATUS_W-1:0] m_tuser;
	logic                         divisor_we = 1'b0;
	logic [W-1:0]                 divisor    = 32'd1;

	// divisor constants as the block should derive them
	logic [W-1:0] divisor_cfg;
	logic [W-1:0] magic_mul;
	logic [5:0]   quot_shift;
	logic [1:0]   div_path;

	logic [W-1:0] dividend_queue[$];
	quot_item_t   quotient_expected[$];

	int unsigned errors    = 0;
	bit          calm      = 1'b0;   // no random idling on either side
	int unsigned hold_req  = 0;      // bumped to ask the monitor for a long stall
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	signed_divide_by_constant #(
		.WIDTH(W)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),     // [31:0] dividend
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),     // [31:0] quotient
		.m_tuser   (m_tuser),     // [1:0] status
		.divisor_we(divisor_we),
		.divisor   (divisor)
	);

	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int unsigned msb_index(input logic [W-1:0] m);
		logic [W-1:0] v;
		int unsigned  l;
		v = m;
		l = 0;
		while (v > 1) begin
			v = v >> 1;
			l++;
		end
		return l;
	endfunction

	// pick the path and its constants for a new divisor
	function automatic void load_divisor(input logic [W-1:0] d);
		logic [W-1:0] mag;
		logic [W-1:0] m;
		logic [63:0]  q;
		int unsigned  l;
		divisor_cfg = d;
		magic_mul   = '0;
		quot_shift  = '0;
		div_path    = sdc_pkg::PATH_IDENT;
		mag = d[W-1] ? -d : d;
		// zero is flagged at divide time, one is a pass-through
		if (d == 0 || d == 1)
			return;
		if (d == '1) begin
			div_path = sdc_pkg::PATH_NEG;
			return;
		end
		if ((mag & (mag - 1)) == 0) begin
			div_path   = sdc_pkg::PATH_POW2;
			quot_shift = 6'(msb_index(mag));
			return;
		end
		// magic: ceil(2^(W-1+l) / |d|), then strip trailing zeros while l stays >= 1
		l = msb_index(mag) + 1;
		q = (64'd1 << (W - 1 + l)) / mag;
		m = q[W-1:0] + 1;
		while (!m[0] && l > 1) begin
			m = m >> 1;
			l--;
		end
		magic_mul  = m;
		quot_shift = 6'(l);
		div_path   = sdc_pkg::PATH_MAGIC;
	endfunction

	function automatic quot_item_t divide_item(input logic [W-1:0] n);
		quot_item_t         r;
		logic [W-1:0]       t;
		logic [W-1:0]       bias;
		logic [W-1:0]       hw;
		logic [W-1:0]       sgn;
		logic [W-1:0]       qd;
		logic signed [63:0] prod;
		r.dividend = n;
		r.quotient = '0;
		r.status   = sdc_pkg::STAT_OK;
		if (divisor_cfg == 0) begin
			r.status = sdc_pkg::STAT_DIVZERO;
		end else begin
			case (div_path)
				sdc_pkg::PATH_IDENT: r.quotient = n;
				sdc_pkg::PATH_NEG: begin
					r.quotient = -n;
					if (n == MIN_VAL)
						r.status = sdc_pkg::STAT_OVF;   // wraps back to MIN
				end
				sdc_pkg::PATH_POW2: begin
					// add |d|-1 to negative dividends so the shift truncates toward zero
					t          = $signed(n) >>> (quot_shift - 1);
					bias       = t >> (W - quot_shift);
					r.quotient = $signed(n + bias) >>> quot_shift;
					if (divisor_cfg[W-1])
						r.quotient = -r.quotient;
				end
				default: begin
					prod = $signed({{W{n[W-1]}}, n}) * $signed({{W{magic_mul[W-1]}}, magic_mul});
					hw   = prod[2*W-1:W];
					// multiplier with top bit set reads as negative, fix by adding n
					if (magic_mul[W-1])
						hw = hw + n;
					sgn        = {W{n[W-1]}};
					qd         = $signed(hw) >>> (quot_shift - 1);
					r.quotient = divisor_cfg[W-1] ? sgn - qd : qd - sgn;
				end
			endcase
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus values

	function automatic logic [W-1:0] pick_dividend();
		logic [W-1:0] v;
		logic [W-1:0] k;
		case ($urandom_range(9))
			0: v = $urandom_range(200) - 100;
			1: begin
				// near a multiple of the divisor, where truncation flips
				k = $urandom_range(2000) - 1000;
				v = divisor_cfg * k + ($urandom_range(2) - 1);
			end
			2: begin
				v = $urandom() >> $urandom_range(W - 1);
				if ($urandom_range(1))
					v = -v;
			end
			3: begin
				case ($urandom_range(5))
					0: v = MIN_VAL;
					1: v = MAX_VAL;
					2: v = MIN_VAL + 1;
					3: v = '1;
					4: v = '0;
					default: v = 32'd1;
				endcase
			end
			default: v = $urandom();
		endcase
		return v;
	endfunction

	function automatic logic [W-1:0] pick_divisor();
		logic [W-1:0] v;
		case ($urandom_range(3))
			0: v = $urandom();
			1: v = $urandom() >> $urandom_range(W - 1);
			2: v = 32'd1 << $urandom_range(W - 1);
			default: v = $urandom_range(1000, 3);
		endcase
		if ($urandom_range(1))
			v = -v;
		return v;
	endfunction

	// ---------------------------------------------------------------- sequencing

	// wait until nothing is queued, offered or in flight; sampled on the falling edge
	task automatic drain();
		@(negedge clk);
		while (dividend_queue.size() != 0 || s_tvalid || quotient_expected.size() != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);
	endtask

	task automatic write_divisor(input logic [W-1:0] d);
		drain();
		@(posedge clk);
		divisor_we <= 1'b1;
		divisor    <= d;
		@(posedge clk);
		divisor_we <= 1'b0;
		load_divisor(d);
	endtask

	task automatic feed_random(input int unsigned count, input bit pause);
		for (int unsigned i = 0; i < count; i++) begin
			// sender stops mid-phase until every result is back
			if (i == count / 2 && (pause || $urandom_range(3) == 0))
				drain();
			dividend_queue.push_back(pick_dividend());
		end
	endtask

	task automatic report_mismatch(input string what, input logic [W-1:0] n,
			input logic [W-1:0] got, input logic [W-1:0] want);
		$display("mismatch %s: divisor %h dividend %h got %h want %h",
			what, divisor_cfg, n, got, want);
		errors++;
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin
		if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				quotient_expected.push_back(divide_item(s_tdata));
			if (dividend_queue.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= dividend_queue.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		quot_item_t want;
		if (m_tvalid && m_tready) begin
			if (quotient_expected.size() == 0) begin
				report_mismatch("unexpected item", '0, m_tdata, '0);
			end else begin
				want = quotient_expected.pop_front();
				if (m_tdata !== want.quotient)
					report_mismatch("quotient", want.dividend, m_tdata, want.quotient);
				if (m_tuser !== want.status)
					report_mismatch("status", want.dividend, W'(m_tuser), W'(want.status));
			end
		end
		// a long hold lets the pipeline fill and push back on s_tready
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 9);
		end
	end

	// ---------------------------------------------------------------- test flow

	logic [W-1:0] fixed_divs[15] = '{
		32'hffff_ffff, 32'd0, 32'd2, 32'hffff_fffe, MIN_VAL, MAX_VAL, MIN_VAL + 1,
		32'd3, 32'hffff_fffd, 32'd7, 32'd10, 32'd641, 32'hffff_fc18, 32'h4000_0000,
		32'd1
	};

	initial begin
		load_divisor(32'd1);   // reset value
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset divisor of one: pass-through of the extremes
		dividend_queue.push_back('0);
		dividend_queue.push_back(32'd1);
		dividend_queue.push_back('1);
		dividend_queue.push_back(MIN_VAL);
		dividend_queue.push_back(MAX_VAL);
		feed_random(45, 1'b0);

		for (int p = 0; p < 15; p++) begin
			write_divisor(fixed_divs[p]);
			calm = (p >= 4 && p <= 6);
			if (p == 8)
				hold_req++;
			case (p)
				0: begin
					// MIN / -1 overflows
					dividend_queue.push_back(MIN_VAL);
					dividend_queue.push_back(MAX_VAL);
					dividend_queue.push_back('0);
				end
				1: begin
					// zero divisor
					dividend_queue.push_back(MIN_VAL);
					dividend_queue.push_back(32'd1);
				end
				4: begin
					dividend_queue.push_back(MIN_VAL);
					dividend_queue.push_back(MIN_VAL + 1);
					dividend_queue.push_back(MAX_VAL);
				end
				7: begin
					dividend_queue.push_back(MAX_VAL);
					dividend_queue.push_back(MIN_VAL);
					dividend_queue.push_back(32'hffff_fffd);
					dividend_queue.push_back(32'd3);
					dividend_queue.push_back(32'hffff_fffe);
					dividend_queue.push_back(32'd2);
				end
				default: ;
			endcase
			feed_random(45, p == 10);
		end
		calm = 1'b0;

		for (int p = 0; p < 14; p++) begin
			write_divisor(pick_divisor());
			feed_random(45, 1'b0);
		end

		drain();
		repeat (10) @(posedge clk);
		if (quotient_expected.size() != 0)
			report_mismatch("missing item", '0, '0, '0);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
